// ===== rtl/kdpc_pkg.sv =====
// kdpc_pkg: shared types and constants of the key debounce press classifier
// no dependencies; used by the interfaces and all rtl modules
`timescale 1ns / 1ps

package kdpc_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int EVT_W     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TIME   = 8'd0,
        CFG_LONG_PRESS_TIME = 8'd1
    } t_cfg_index;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef enum logic [EVT_W-1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_key_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } t_cfg;

    // one poll as held in the input register
    typedef struct packed {
        logic              raw_pressed;
        logic [TIME_W-1:0] now_ms;
    } t_poll;

endpackage

// ===== rtl/kdpc_ifs.sv =====
// kdpc_ifs: valid/ready channel interfaces for polls, events and config writes
// depends on kdpc_pkg
`timescale 1ns / 1ps

interface kdpc_poll_if import kdpc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              raw_pressed;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output raw_pressed, output now_ms, input ready);
    modport sink   (input valid, input raw_pressed, input now_ms, output ready);
endinterface

interface kdpc_event_if import kdpc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EVT_W-1:0] key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

interface kdpc_cfg_if import kdpc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/kdpc_cfg_regs.sv =====
// kdpc_cfg_regs: debounce and long-press time registers behind the write channel
// depends on kdpc_pkg and kdpc_ifs
`timescale 1ns / 1ps

module kdpc_cfg_regs import kdpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kdpc_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_DEBOUNCE_TIME:   n_cfg.debounce_time   = i_cfg.data;
                CFG_LONG_PRESS_TIME: n_cfg.long_press_time = i_cfg.data;
                default:             n_cfg = r_cfg;  // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time   <= DEBOUNCE_RESET;
            r_cfg.long_press_time <= LONG_PRESS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/kdpc_classifier.sv =====
// kdpc_classifier: debounce and press state with its single-pass update logic
// depends on kdpc_pkg
`timescale 1ns / 1ps

module kdpc_classifier import kdpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_poll      i_poll,
    input  t_cfg       i_cfg,
    output t_key_event o_event
);

    logic              r_last_raw, n_last_raw;
    logic              r_stable,   n_stable;
    logic              r_long_sent, n_long_sent;
    logic [TIME_W-1:0] r_bounce_stamp, n_bounce_stamp;
    logic [TIME_W-1:0] r_press_stamp,  n_press_stamp;

    logic [TIME_W-1:0] since_bounce;
    logic [TIME_W-1:0] since_press;
    logic              window_open;
    logic              stable_change;

    always_comb begin
        n_last_raw     = i_poll.raw_pressed;
        n_bounce_stamp = (i_poll.raw_pressed != r_last_raw) ? i_poll.now_ms
                                                            : r_bounce_stamp;
        since_bounce   = i_poll.now_ms - n_bounce_stamp;
        window_open    = since_bounce < {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_time};
        stable_change  = i_poll.raw_pressed != r_stable;

        n_stable      = r_stable;
        n_long_sent   = r_long_sent;
        n_press_stamp = r_press_stamp;
        o_event       = EVT_NONE;

        if (!window_open) begin
            n_stable = i_poll.raw_pressed;
            if (stable_change && i_poll.raw_pressed) begin
                n_press_stamp = i_poll.now_ms;
                n_long_sent   = 1'b0;
            end
        end
        since_press = i_poll.now_ms - n_press_stamp;

        if (!window_open) begin
            if (stable_change && !i_poll.raw_pressed) begin
                // release: short unless a long was already reported
                if (!r_long_sent) begin
                    o_event = EVT_SHORT;
                end
            end else if (n_stable && !n_long_sent &&
                         since_press >= {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_time}) begin
                n_long_sent = 1'b1;
                o_event     = EVT_LONG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= 1'b0;
            r_stable       <= 1'b0;
            r_long_sent    <= 1'b0;
            r_bounce_stamp <= '0;
            r_press_stamp  <= '0;
        end else if (i_step) begin
            r_last_raw     <= n_last_raw;
            r_stable       <= n_stable;
            r_long_sent    <= n_long_sent;
            r_bounce_stamp <= n_bounce_stamp;
            r_press_stamp  <= n_press_stamp;
        end
    end

endmodule

// ===== rtl/key_debounce_press_classifier_core.sv =====
// key_debounce_press_classifier_core: top level, input and result registers
// depends on kdpc_pkg, kdpc_ifs, kdpc_cfg_regs, kdpc_classifier
//
//   channel   dir  handshake      payload
//   i_poll    in   valid/ready    raw_pressed[0], now_ms[31:0]
//   o_event   out  valid/ready    key_event[1:0]  (0 none, 1 short, 2 long)
//   i_cfg     in   valid/ready    index[7:0], data[15:0], ready always high
//
// one item per cycle sustained while the output is not stalled; an accepted
// item goes through the input register, then classifier logic into the result
// register. state advances when an item moves from the input register into
// the result register. reset (synchronous, active low) clears the key state
// and loads the default times. a stalled output holds its result while the
// input register still takes one more item if it is empty.
`timescale 1ns / 1ps

module key_debounce_press_classifier_core import kdpc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kdpc_poll_if.sink    i_poll,
    kdpc_event_if.source o_event,
    kdpc_cfg_if.sink     i_cfg
);

    t_cfg       cfg;
    t_key_event step_event;

    logic       r_in_valid;
    t_poll      r_in_poll;
    logic       r_out_valid;
    t_key_event r_out_event;

    logic       out_free;
    logic       step;

    assign out_free     = !r_out_valid || o_event.ready;
    assign step         = r_in_valid && out_free;
    assign i_poll.ready = !r_in_valid || out_free;

    kdpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    kdpc_classifier u_classifier (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_poll  (r_in_poll),
        .i_cfg   (cfg),
        .o_event (step_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_poll.ready) begin
                r_in_valid <= i_poll.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_poll.valid && i_poll.ready) begin
            r_in_poll.raw_pressed <= i_poll.raw_pressed;
            r_in_poll.now_ms      <= i_poll.now_ms;
        end
        if (step) begin
            r_out_event <= step_event;
        end
    end

    assign o_event.valid     = r_out_valid;
    assign o_event.key_event = r_out_event;

endmodule
